/* rtl/lfgf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfgf_pkg
// shared types and constants of the forwarding engine with group flood
// ----------------------------------------------------------------------------
package lfgf_pkg;

    // defaults of the top level parameters
    localparam int NUM_PORTS_DEF     = 8;
    localparam int UCAST_ENTRIES_DEF = 8;
    localparam int GROUP_ENTRIES_DEF = 8;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 3;
    localparam int LID_W    = 16;
    localparam int PORT_W   = 4;
    localparam int OUT_W    = 3;
    localparam int MEMBER_W = 8;
    localparam int TAG_W    = 16;

    // tdata widths of the slave and master sides
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD   = 2'd0,
        CMD_WR_UC = 2'd1,
        CMD_WR_GR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic wr_uc;
        logic wr_gr;
        logic lookup;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pend_zero;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage : lfgf_pkg
`default_nettype wire

/* rtl/lid_forwarding_with_group_flood.sv */
`default_nettype none
// frame path: a frame beat is captured in idle, looked up in the lookup state,
//   and its first copy is registered at the output from the emit state
// flow: write beats are taken in idle and do not leave it; a frame sends one
//   copy per cycle from the pending port mask while the output is free
// reset: synchronous, active low; clears live bits, pending mask, sequencer and output valid
// ----------------------------------------------------------------------------
// lid_forwarding_with_group_flood
// switch forwarding engine: unicast table and group flood table with
// source port pruning, fed and drained over stream channels
// ----------------------------------------------------------------------------
module lid_forwarding_with_group_flood
    import lfgf_pkg::*;
#(
    parameter int NUM_PORTS     = NUM_PORTS_DEF,
    parameter int UCAST_ENTRIES = UCAST_ENTRIES_DEF,
    parameter int GROUP_ENTRIES = GROUP_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // entry_index[2:0], entry_valid[3], dest_lid[19:4], src_lid[35:20],
    // entry_port[39:36], entry_mask[47:40], frame_tag[63:48]
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // cmd[1:0]
    input  wire logic [CMD_W-1:0]     i_s_tuser,
    // master side
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // out_port[3:0], out_tag[19:4], zero fill[23:20]
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // is_group[0]
    output logic [0:0]                o_m_tuser,
    // last_copy
    output logic                      o_m_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: idle takes beats, writes land in the tables at once,
    // frames go through lookup and then one copy per free output slot
    lfgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // tables, lookup, pending mask and the output register that parts
    // the two sides
    lfgf_datapath #(
        .NUM_PORTS     (NUM_PORTS),
        .UCAST_ENTRIES (UCAST_ENTRIES),
        .GROUP_ENTRIES (GROUP_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef ASSERT_OFF
    // a copy is only loaded into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("copy loaded into occupied output slot");

    // no new beat is taken while copies are still being released
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_cmd.emit && !w_cmd.lookup)
        else $error("beat taken while a frame is in flight");

    // a unicast forward is always a single, last copy
    a_ucast_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("unicast result without last flag");

    // after the last copy is loaded the sequencer returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_stat.last) |=> o_s_tready)
        else $error("not idle after last copy");
`endif

endmodule : lid_forwarding_with_group_flood
`default_nettype wire

/* rtl/lfgf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfgf_ctrl
// sequencer: takes a beat, runs the lookup, then while the output is free releases one copy per cycle
// ----------------------------------------------------------------------------
module lfgf_ctrl
    import lfgf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic [CMD_W-1:0] i_s_tuser,
    input  wire t_dp_stat         i_stat,
    output logic                  o_s_tready,
    output t_dp_cmd               o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    unique case (t_cmd'(i_s_tuser))
                        CMD_FWD: begin
                            o_cmd.cap = 1'b1;
                            n_state   = ST_LOOKUP;
                        end
                        CMD_WR_UC: o_cmd.wr_uc = 1'b1;
                        CMD_WR_GR: o_cmd.wr_gr = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.pend_zero) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule : lfgf_ctrl
`default_nettype wire

/* rtl/lfgf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfgf_datapath
// unicast and group tables, lookup, pending port mask and output register
// ----------------------------------------------------------------------------
module lfgf_datapath
    import lfgf_pkg::*;
#(
    parameter int NUM_PORTS     = NUM_PORTS_DEF,
    parameter int UCAST_ENTRIES = UCAST_ENTRIES_DEF,
    parameter int GROUP_ENTRIES = GROUP_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_m_tready,
    output t_dp_stat                  o_stat,
    output logic                      o_m_tvalid,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic [0:0]                o_m_tuser,
    output logic                      o_m_tlast
);

    // a 3-bit slot index reaches eight slots at most
    localparam int MAX_SLOTS = 1 << IDX_W;
    localparam int UC_DEPTH  = (UCAST_ENTRIES < MAX_SLOTS) ? UCAST_ENTRIES : MAX_SLOTS;
    localparam int GR_DEPTH  = (GROUP_ENTRIES < MAX_SLOTS) ? GROUP_ENTRIES : MAX_SLOTS;
    localparam int PORT_LIM  = (NUM_PORTS < MEMBER_W) ? NUM_PORTS : MEMBER_W;
    localparam logic [MEMBER_W-1:0] PORT_MASK = MEMBER_W'((64'd1 << PORT_LIM) - 64'd1);

    // beat fields
    logic [IDX_W-1:0]    w_idx;
    logic                w_valid;
    logic [LID_W-1:0]    w_dest;
    logic [LID_W-1:0]    w_src;
    logic [PORT_W-1:0]   w_port;
    logic [MEMBER_W-1:0] w_mask;
    logic [TAG_W-1:0]    w_tag;

    assign w_idx   = i_s_tdata[2:0];
    assign w_valid = i_s_tdata[3];
    assign w_dest  = i_s_tdata[19:4];
    assign w_src   = i_s_tdata[35:20];
    assign w_port  = i_s_tdata[39:36];
    assign w_mask  = i_s_tdata[47:40];
    assign w_tag   = i_s_tdata[63:48];

    // tables
    logic [LID_W-1:0]    r_uc_key  [UC_DEPTH];
    logic [OUT_W-1:0]    r_uc_out  [UC_DEPTH];
    logic [UC_DEPTH-1:0] r_uc_live;
    logic [LID_W-1:0]    r_gr_key  [GR_DEPTH];
    logic [MEMBER_W-1:0] r_gr_mem  [GR_DEPTH];
    logic [GR_DEPTH-1:0] r_gr_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uc_live <= '0;
        end else begin
            for (int i = 0; i < UC_DEPTH; i++) begin
                if (i_cmd.wr_uc && w_idx == IDX_W'(i)) begin
                    r_uc_live[i] <= w_valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < UC_DEPTH; i++) begin
            if (i_cmd.wr_uc && w_idx == IDX_W'(i)) begin
                r_uc_key[i] <= w_dest;
                r_uc_out[i] <= OUT_W'(w_port - PORT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gr_live <= '0;
        end else begin
            for (int i = 0; i < GR_DEPTH; i++) begin
                if (i_cmd.wr_gr && w_idx == IDX_W'(i)) begin
                    r_gr_live[i] <= w_valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < GR_DEPTH; i++) begin
            if (i_cmd.wr_gr && w_idx == IDX_W'(i)) begin
                r_gr_key[i] <= w_dest;
                r_gr_mem[i] <= w_mask;
            end
        end
    end

    // captured frame
    logic [LID_W-1:0] r_dest;
    logic [LID_W-1:0] r_src;
    logic [TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_dest <= w_dest;
            r_src  <= w_src;
            r_tag  <= w_tag;
        end
    end

    // lookup, lowest matching slot wins
    logic                w_gr_hit, w_dst_hit, w_src_hit;
    logic [MEMBER_W-1:0] w_gr_sel;
    logic [OUT_W-1:0]    w_dst_out, w_src_out;
    logic [MEMBER_W-1:0] w_lk_pend;

    always_comb begin
        w_gr_hit  = 1'b0;
        w_gr_sel  = '0;
        w_dst_hit = 1'b0;
        w_dst_out = '0;
        w_src_hit = 1'b0;
        w_src_out = '0;
        for (int i = GR_DEPTH - 1; i >= 0; i--) begin
            if (r_gr_live[i] && r_gr_key[i] == r_dest) begin
                w_gr_hit = 1'b1;
                w_gr_sel = r_gr_mem[i];
            end
        end
        for (int i = UC_DEPTH - 1; i >= 0; i--) begin
            if (r_uc_live[i] && r_uc_key[i] == r_dest) begin
                w_dst_hit = 1'b1;
                w_dst_out = r_uc_out[i];
            end
            if (r_uc_live[i] && r_uc_key[i] == r_src) begin
                w_src_hit = 1'b1;
                w_src_out = r_uc_out[i];
            end
        end
        if (w_gr_hit) begin
            // members within the port count, source port pruned
            w_lk_pend = w_gr_sel & PORT_MASK;
            if (w_src_hit) begin
                w_lk_pend[w_src_out] = 1'b0;
            end
        end else if (w_dst_hit) begin
            w_lk_pend = '0;
            w_lk_pend[w_dst_out] = 1'b1;
        end else begin
            w_lk_pend = '0;
        end
    end

    // pending ports of the current frame
    logic [MEMBER_W-1:0] r_pend;
    logic                r_grp;
    logic [MEMBER_W-1:0] w_low;
    logic [PORT_W-1:0]   w_low_port;

    always_comb begin
        w_low      = '0;
        w_low_port = '0;
        for (int k = MEMBER_W - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_low      = '0;
                w_low[k]   = 1'b1;
                w_low_port = PORT_W'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_cmd.lookup) begin
            r_pend <= w_lk_pend;
        end else if (i_cmd.emit) begin
            r_pend <= r_pend & ~w_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_grp <= w_gr_hit;
        end
    end

    // output register
    logic              r_out_valid;
    logic [PORT_W-1:0] r_out_port;
    logic [TAG_W-1:0]  r_out_tag;
    logic              r_out_grp;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_port <= w_low_port;
            r_out_tag  <= r_tag;
            r_out_grp  <= r_grp;
            r_out_last <= o_stat.last;
        end
    end

    assign o_stat.pend_zero = (r_pend == '0);
    assign o_stat.last      = ((r_pend & ~w_low) == '0);
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_tag, r_out_port};
    assign o_m_tuser  = r_out_grp;
    assign o_m_tlast  = r_out_last;

endmodule : lfgf_datapath
`default_nettype wire
